@@ rtl/core/iait_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iait_pkg
// Shared types and constants of the input activity idle timer.
// ----------------------------------------------------------------------------
package iait_pkg;

   localparam int DEVICES = 16;
   localparam int AXES = 64;
   localparam int AXIS_CODE_LIMIT = 64;
   localparam int SLOTS = DEVICES * AXES;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int CMD_W = 2;
   localparam int DEV_W = 4;
   localparam int ETYPE_W = 5;
   localparam int CODE_W = 10;
   localparam int VALUE_W = 32;
   localparam int AXVAL_W = 16;
   localparam int CNT_W = 16;

   localparam int EPOCH_W = 4;
   localparam logic [EPOCH_W-1:0] EPOCH_NONE = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;
   localparam int RAM_W = EPOCH_W + AXVAL_W;

   localparam int REQ_FIELDS_W = DEV_W + ETYPE_W + CODE_W + VALUE_W + 1;
   localparam int REQ_TDATA_W = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 + CNT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_EVENT   = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_FINISH  = 2'd2,
      CMD_RESCAN  = 2'd3
   } cmd_type;

   localparam logic [ETYPE_W-1:0] EV_KEY = 5'd1;
   localparam logic [ETYPE_W-1:0] EV_REL = 5'd2;
   localparam logic [ETYPE_W-1:0] EV_ABS = 5'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEVER_LAUNCH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AXIS_DEADZONE = 2'd2;

   localparam logic [CNT_W-1:0] DEFAULT_TIMEOUT = 16'd180;
   localparam logic [AXVAL_W-1:0] DEFAULT_DEADZONE = 16'd2000;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef struct packed {
      cmd_type               cmd;
      logic [DEV_W-1:0]      device;
      logic [ETYPE_W-1:0]    event_type;
      logic [CODE_W-1:0]     event_code;
      logic [VALUE_W-1:0]    event_value;
      logic                  menu_showing;
   } req_item_type;

   typedef struct packed {
      logic [CNT_W-1:0] idle_count;
      logic             launch_screensaver;
      logic             real_activity;
   } rsp_item_type;

   function automatic logic [SLOT_W-1:0] slot_of(logic [DEV_W-1:0] dev,
                                                 logic [CODE_W-1:0] code);
      int s;
      s = int'(dev) * AXES + int'(code);
      return SLOT_W'(s);
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/input_activity_idle_timer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// input_activity_idle_timer
// Qualifies input events as user activity and times idleness for launching
// a screensaver.
//
// Items enter on the req_ stream: req_tuser carries the command (event, tick,
// finish, rescan) and req_tdata the event fields. Every item produces exactly
// one result transfer on the rsp_ stream, via item_ff and then rsp_ff. One item
// is accepted per cycle unless the input stalls; the per-axis history lives in
// a RAM that is read when the item is accepted and written back when it leaves
// item_ff, with a bypass register covering back-to-back hits on the same axis.
// Clearing the seen marks is done by advancing an epoch tag stored with each
// axis value. After reset, and on every fifteenth finish or rescan, a sweep
// rewrites all 1024 entries of the RAM; req_tready is low while it runs,
// while csr_ writes are still taken. Results wait in an output register when
// rsp_tready is low; one item can still be accepted behind it before the
// input stalls. Configuration is written through the csr_ port.
// ----------------------------------------------------------------------------
module input_activity_idle_timer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // device, event_type, event_code, event_value, menu_showing
   input  wire logic [iait_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // cmd
   input  wire logic [iait_pkg::CMD_W-1:0]          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // real_activity, launch_screensaver, idle_count
   output logic      [iait_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [iait_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [iait_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   iait_pkg::req_item_type req_item;
   iait_pkg::req_item_type item_ff;
   iait_pkg::rsp_item_type rsp_ff, rsp_in;

   logic                              item_valid_ff;
   logic                              rsp_valid_ff;
   logic                              out_free, item_adv, req_fire, wrap_start;
   logic [iait_pkg::CNT_W-1:0]        timeout_ff;
   logic                              never_launch_ff;
   logic [iait_pkg::AXVAL_W-1:0]      deadzone_ff;
   logic [iait_pkg::CNT_W-1:0]        count_ff, count_in, tick_count, limit;
   logic                              saver_ff, saver_in;
   logic [iait_pkg::EPOCH_W-1:0]      epoch_ff, epoch_in;
   logic                              sweep_ff, sweep_in;
   logic [iait_pkg::SLOT_W-1:0]       sweep_addr_ff, sweep_addr_in;
   logic                              byp_valid_ff;
   logic [iait_pkg::SLOT_W-1:0]       byp_addr_ff;
   logic [iait_pkg::AXVAL_W-1:0]      byp_value_ff;
   logic [iait_pkg::SLOT_W-1:0]       item_slot_ff, req_slot;
   logic [iait_pkg::RAM_W-1:0]        ram_rd_data, ram_wr_data;
   logic                              ram_wr_en;
   logic [iait_pkg::SLOT_W-1:0]       ram_wr_addr;
   logic [iait_pkg::EPOCH_W-1:0]      last_tag;
   logic [iait_pkg::AXVAL_W-1:0]      last_value, cur_value;
   logic                              dev_ok, code_ok, axis_write, seen, is_clear;
   logic signed [iait_pkg::AXVAL_W:0] delta;
   logic [iait_pkg::AXVAL_W:0]        abs_delta;
   logic                              real_act, launch;

   assign req_item = '{
      cmd:          iait_pkg::cmd_type'(req_tuser),
      device:       req_tdata[3:0],
      event_type:   req_tdata[8:4],
      event_code:   req_tdata[18:9],
      event_value:  req_tdata[50:19],
      menu_showing: req_tdata[51]
   };
   assign req_slot = iait_pkg::slot_of(req_item.device, req_item.event_code);

   assign csr_ready = 1'b1;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign item_adv = item_valid_ff && out_free;
   assign is_clear = (item_ff.cmd == iait_pkg::CMD_FINISH) ||
                     (item_ff.cmd == iait_pkg::CMD_RESCAN);
   assign wrap_start = item_adv && is_clear && (epoch_ff == iait_pkg::EPOCH_LAST);
   assign req_tready = !sweep_ff && (!item_valid_ff || out_free) && !wrap_start;
   assign req_fire = req_tvalid && req_tready;

   // Event qualification.
   assign dev_ok = 32'(item_ff.device) < 32'(iait_pkg::DEVICES);
   assign code_ok = (32'(item_ff.event_code) < 32'(iait_pkg::AXES)) &&
                    (32'(item_ff.event_code) < 32'(iait_pkg::AXIS_CODE_LIMIT));
   assign axis_write = (item_ff.cmd == iait_pkg::CMD_EVENT) && dev_ok &&
                       (item_ff.event_type == iait_pkg::EV_ABS) && code_ok;

   assign last_tag = (byp_valid_ff && byp_addr_ff == item_slot_ff) ?
                     epoch_ff : ram_rd_data[iait_pkg::RAM_W-1 -: iait_pkg::EPOCH_W];
   assign last_value = (byp_valid_ff && byp_addr_ff == item_slot_ff) ?
                       byp_value_ff : ram_rd_data[iait_pkg::AXVAL_W-1:0];
   assign cur_value = item_ff.event_value[iait_pkg::AXVAL_W-1:0];
   assign seen = (last_tag == epoch_ff);
   assign delta = $signed({cur_value[iait_pkg::AXVAL_W-1], cur_value}) -
                  $signed({last_value[iait_pkg::AXVAL_W-1], last_value});
   assign abs_delta = delta[iait_pkg::AXVAL_W] ? (iait_pkg::AXVAL_W+1)'(-delta)
                                                : (iait_pkg::AXVAL_W+1)'(delta);

   always_comb begin
      real_act = 1'b0;
      if (item_ff.cmd == iait_pkg::CMD_EVENT && dev_ok) begin
         if (item_ff.event_type == iait_pkg::EV_KEY) begin
            real_act = (item_ff.event_value == 32'd1);
         end else if (item_ff.event_type == iait_pkg::EV_REL) begin
            real_act = 1'b1;
         end else if (axis_write) begin
            real_act = seen && (abs_delta > {1'b0, deadzone_ff});
         end
      end
   end

   assign limit = (timeout_ff == '0) ? iait_pkg::DEFAULT_TIMEOUT : timeout_ff;
   assign tick_count = (count_ff == iait_pkg::CNT_MAX) ? count_ff
                                                        : count_ff + 1'b1;
   assign launch = (item_ff.cmd == iait_pkg::CMD_TICK) && (tick_count >= limit) &&
                   item_ff.menu_showing && !never_launch_ff && !saver_ff;

   always_comb begin
      count_in = count_ff;
      saver_in = saver_ff;
      epoch_in = epoch_ff;
      if (item_adv) begin
         unique case (item_ff.cmd)
            iait_pkg::CMD_EVENT: begin
               if (real_act) begin
                  count_in = '0;
               end
            end
            iait_pkg::CMD_TICK: begin
               count_in = tick_count;
               if (launch) begin
                  saver_in = 1'b1;
               end
            end
            iait_pkg::CMD_FINISH: begin
               count_in = '0;
               saver_in = 1'b0;
               epoch_in = (epoch_ff == iait_pkg::EPOCH_LAST) ? iait_pkg::EPOCH_FIRST
                                                             : epoch_ff + 1'b1;
            end
            iait_pkg::CMD_RESCAN: begin
               epoch_in = (epoch_ff == iait_pkg::EPOCH_LAST) ? iait_pkg::EPOCH_FIRST
                                                             : epoch_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_in = '{idle_count: count_in, launch_screensaver: launch,
                     real_activity: real_act};

   always_comb begin
      sweep_in = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
         if (32'(sweep_addr_ff) == 32'(iait_pkg::SLOTS - 1)) begin
            sweep_in = 1'b0;
            sweep_addr_in = '0;
         end
      end else if (wrap_start) begin
         sweep_in = 1'b1;
         sweep_addr_in = '0;
      end
   end

   always_comb begin
      if (sweep_ff) begin
         ram_wr_en = 1'b1;
         ram_wr_addr = sweep_addr_ff;
         ram_wr_data = {iait_pkg::EPOCH_NONE, {iait_pkg::AXVAL_W{1'b0}}};
      end else begin
         ram_wr_en = item_adv && axis_write;
         ram_wr_addr = item_slot_ff;
         ram_wr_data = {epoch_ff, cur_value};
      end
   end

   iait_ram #(
      .WIDTH (iait_pkg::RAM_W),
      .DEPTH (iait_pkg::SLOTS)
   ) u_axis_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_slot),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff <= iait_pkg::DEFAULT_TIMEOUT;
         never_launch_ff <= 1'b0;
         deadzone_ff <= iait_pkg::DEFAULT_DEADZONE;
         count_ff <= '0;
         saver_ff <= 1'b0;
         epoch_ff <= iait_pkg::EPOCH_FIRST;
         sweep_ff <= 1'b1;
         sweep_addr_ff <= '0;
         byp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            item_valid_ff <= 1'b1;
         end else if (item_adv) begin
            item_valid_ff <= 1'b0;
         end
         if (item_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               iait_pkg::CSR_IDLE_TIMEOUT:  timeout_ff <= csr_wdata;
               iait_pkg::CSR_NEVER_LAUNCH:  never_launch_ff <= csr_wdata[0];
               iait_pkg::CSR_AXIS_DEADZONE: deadzone_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         count_ff <= count_in;
         saver_ff <= saver_in;
         epoch_ff <= epoch_in;
         sweep_ff <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
         if (req_fire) begin
            byp_valid_ff <= item_adv && axis_write;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_item;
         item_slot_ff <= req_slot;
         byp_addr_ff <= item_slot_ff;
         byp_value_ff <= cur_value;
      end
      if (item_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = iait_pkg::RSP_TDATA_W'(rsp_ff);

endmodule
`default_nettype wire

@@ rtl/core/iait_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iait_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module iait_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/iait_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iait_checker
// Port-level checks of the input activity idle timer, bound to the top level.
// ----------------------------------------------------------------------------
module iait_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic [iait_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input wire logic [iait_pkg::CMD_W-1:0]          req_tuser,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [iait_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input wire logic                                csr_valid,
   input wire logic                                csr_ready,
   input wire logic [iait_pkg::CSR_INDEX_W-1:0]    csr_index,
   input wire logic [iait_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // A stalled result transfer keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Activity always leaves the idle count at zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[17:2] == '0)
      else $error("activity with nonzero idle count");

   // A launch never coincides with activity and follows at least one idle second.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> !rsp_tdata[0] && rsp_tdata[17:2] != '0)
      else $error("launch with activity or zero idle count");

   // The axis store sweep after reset holds off the input.
   assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("input taken right after reset");

endmodule

bind input_activity_idle_timer iait_checker u_iait_checker (.*);
`default_nettype wire

@@ tb/sv/input_activity_idle_timer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_activity_idle_timer_test
// Self-checking bench for the input activity idle timer. Stimulus covers
// directed corner cases and weighted random event streams under several
// register settings. Each result transfer is checked against a cycle-free
// prediction of activity, launch and idle count. A closing run without idle
// cycles checks a launch after a longer timeout.
// ----------------------------------------------------------------------------
module input_activity_idle_timer_test;

   import iait_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata = '0;
   logic [CMD_W-1:0]         req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   input_activity_idle_timer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   req_item_type pending[$];
   rsp_item_type awaited[$];
   req_item_type on_wire = '0;
   rsp_item_type next_report;

   bit idling_on = 1'b1;
   int send_gap = 0;
   int recv_stall = 0;
   int mismatches = 0;

   // Predicted state of the block.
   logic [AXVAL_W-1:0] axis_hist [SLOTS];
   bit                 axis_valid [SLOTS];
   logic [CNT_W-1:0]   idle_secs = '0;
   bit                 saver_on = 1'b0;
   logic [CNT_W-1:0]   cfg_timeout = DEFAULT_TIMEOUT;
   bit                 cfg_never = 1'b0;
   logic [AXVAL_W-1:0] cfg_deadzone = DEFAULT_DEADZONE;

   // Last axis value generated per slot, used to aim changes at the deadzone.
   int abs_shadow [SLOTS];

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("MISMATCH %s: got %0d, expected %0d at %0t ns", what, got, want, $time);
   endtask

   function automatic req_item_type make_item(cmd_type c, int dev, int etype, int code,
                                              logic [VALUE_W-1:0] val, bit menu);
      req_item_type it;
      it.cmd = c;
      it.device = DEV_W'(dev);
      it.event_type = ETYPE_W'(etype);
      it.event_code = CODE_W'(code);
      it.event_value = val;
      it.menu_showing = menu;
      return it;
   endfunction

   function automatic void predict_activity(req_item_type it);
      rsp_item_type r;
      int slot;
      int cur_v;
      int diff;
      int limit;
      r = '0;
      limit = (cfg_timeout == 0) ? int'(DEFAULT_TIMEOUT) : int'(cfg_timeout);
      case (it.cmd)
         CMD_EVENT: begin
            if (it.event_type == EV_KEY) begin
               r.real_activity = (it.event_value == 32'd1);
            end else if (it.event_type == EV_REL) begin
               r.real_activity = 1'b1;
            end else if (it.event_type == EV_ABS && int'(it.event_code) < AXIS_CODE_LIMIT
                         && int'(it.event_code) < AXES && int'(it.device) < DEVICES) begin
               slot = int'(it.device) * AXES + int'(it.event_code);
               cur_v = int'($signed(it.event_value[AXVAL_W-1:0]));
               if (axis_valid[slot]) begin
                  diff = cur_v - int'($signed(axis_hist[slot]));
                  if (diff < 0) diff = -diff;
                  r.real_activity = (diff > int'(cfg_deadzone));
               end
               axis_hist[slot] = it.event_value[AXVAL_W-1:0];
               axis_valid[slot] = 1'b1;
            end
            if (r.real_activity) idle_secs = '0;
         end
         CMD_TICK: begin
            if (idle_secs != CNT_MAX) idle_secs = idle_secs + 1'b1;
            if (int'(idle_secs) >= limit && it.menu_showing && !cfg_never && !saver_on) begin
               r.launch_screensaver = 1'b1;
               saver_on = 1'b1;
            end
         end
         default: begin
            foreach (axis_valid[i]) axis_valid[i] = 1'b0;
            if (it.cmd == CMD_FINISH) begin
               saver_on = 1'b0;
               idle_secs = '0;
            end
         end
      endcase
      r.idle_count = idle_secs;
      awaited.push_back(r);
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_activity(on_wire);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 11) == 0) begin
               send_gap <= $urandom_range(0, 9);
               req_tvalid <= 1'b0;
            end else if (pending.size() > 0) begin
               on_wire <= pending[0];
               req_tdata <= {{(REQ_TDATA_W - REQ_FIELDS_W){1'b0}}, pending[0].menu_showing,
                             pending[0].event_value, pending[0].event_code,
                             pending[0].event_type, pending[0].device};
               req_tuser <= pending[0].cmd;
               req_tvalid <= 1'b1;
               void'(pending.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited.size() == 0) begin
               report_mismatch("result transfer with nothing awaited", rsp_tdata, 0);
            end else begin
               next_report = awaited.pop_front();
               if (rsp_tdata[0] !== next_report.real_activity)
                  report_mismatch("real_activity", rsp_tdata[0], next_report.real_activity);
               if (rsp_tdata[1] !== next_report.launch_screensaver)
                  report_mismatch("launch_screensaver", rsp_tdata[1],
                                  next_report.launch_screensaver);
               if (rsp_tdata[CNT_W+1:2] !== next_report.idle_count)
                  report_mismatch("idle_count", rsp_tdata[CNT_W+1:2], next_report.idle_count);
            end
         end
         if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 11) == 0) begin
            recv_stall <= $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_IDLE_TIMEOUT: cfg_timeout = val;
         CSR_NEVER_LAUNCH: cfg_never = val[0];
         CSR_AXIS_DEADZONE: cfg_deadzone = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input int tmo, input int never, input int dz);
      write_csr(CSR_IDLE_TIMEOUT, CSR_DATA_W'(tmo));
      write_csr(CSR_NEVER_LAUNCH, CSR_DATA_W'(never));
      write_csr(CSR_AXIS_DEADZONE, CSR_DATA_W'(dz));
   endtask

   // Returns once every queued item has been transferred and answered.
   task automatic wait_quiet;
      do begin
         @(posedge clock);
         #1;
      end while (pending.size() != 0 || req_tvalid || awaited.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random_phase(input int count, input int tmo, input int never,
                                   input int dz);
      int roll;
      int dev;
      int code;
      int slot;
      int off;
      logic [AXVAL_W-1:0] low16;
      logic [VALUE_W-1:0] val;
      set_config(tmo, never, dz);
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         dev = $urandom_range(0, DEVICES - 1);
         code = $urandom_range(0, 1023);
         val = $urandom;
         if (roll < 35) begin
            pending.push_back(make_item(CMD_TICK, dev, $urandom_range(0, 31), code, val,
                                        $urandom_range(0, 4) != 0));
         end else if (roll < 45) begin
            case ($urandom_range(0, 3))
               0, 1: val = 32'd1;
               2: val = $urandom_range(0, 2);
               default: ;
            endcase
            pending.push_back(make_item(CMD_EVENT, dev, EV_KEY, code, val,
                                        $urandom_range(0, 1)));
         end else if (roll < 52) begin
            pending.push_back(make_item(CMD_EVENT, dev, EV_REL, code, val,
                                        $urandom_range(0, 1)));
         end else if (roll < 80) begin
            // Most axis traffic goes to a few slots so that histories build up.
            if ($urandom_range(0, 9) < 7) begin
               dev = $urandom_range(0, 1) ? DEVICES - 1 : 0;
               code = $urandom_range(0, 1) ? AXES - 1 : 0;
            end else begin
               code = $urandom_range(0, AXES - 1);
            end
            slot = dev * AXES + code;
            case ($urandom_range(0, 3))
               0: off = dz;
               1: off = dz + 1;
               2: off = (dz > 0) ? dz - 1 : 0;
               default: off = $urandom_range(0, 65535);
            endcase
            if ($urandom_range(0, 1)) off = -off;
            low16 = AXVAL_W'(abs_shadow[slot] + off);
            abs_shadow[slot] = int'($signed(low16));
            pending.push_back(make_item(CMD_EVENT, dev, EV_ABS, code,
                                        {val[VALUE_W-1:AXVAL_W], low16},
                                        $urandom_range(0, 1)));
         end else if (roll < 86) begin
            pending.push_back(make_item(CMD_EVENT, dev, EV_ABS,
                                        $urandom_range(AXIS_CODE_LIMIT, 1023), val,
                                        $urandom_range(0, 1)));
         end else if (roll < 92) begin
            roll = $urandom_range(0, 28);
            pending.push_back(make_item(CMD_EVENT, dev, (roll == 0) ? 0 : roll + 3, code,
                                        val, $urandom_range(0, 1)));
         end else if (roll < 96) begin
            pending.push_back(make_item(CMD_FINISH, dev, $urandom_range(0, 31), code, val,
                                        $urandom_range(0, 1)));
         end else begin
            pending.push_back(make_item(CMD_RESCAN, dev, $urandom_range(0, 31), code, val,
                                        $urandom_range(0, 1)));
         end
      end
      wait_quiet();
   endtask

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      foreach (abs_shadow[i]) abs_shadow[i] = 0;
      foreach (axis_valid[i]) axis_valid[i] = 1'b0;
      foreach (axis_hist[i]) axis_hist[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Event qualification at the reset settings.
      pending.push_back(make_item(CMD_EVENT, 0, EV_KEY, 30, 32'd1, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 0, EV_KEY, 30, 32'd0, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 3, EV_KEY, 1023, 32'd2, 1'b1));
      pending.push_back(make_item(CMD_EVENT, 5, EV_KEY, 30, 32'h0001_0001, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 5, EV_KEY, 30, 32'hFFFF_FFFF, 1'b0));
      pending.push_back(make_item(CMD_TICK, 0, 0, 0, 32'd0, 1'b1));
      pending.push_back(make_item(CMD_EVENT, 9, EV_REL, 0, 32'd0, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 1, 0, 0, 32'd1, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 1, 31, 1023, 32'd1, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 15, EV_ABS, 63, 32'd0, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 15, EV_ABS, 63, 32'd2000, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 15, EV_ABS, 63, 32'd4001, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 15, EV_ABS, 63, 32'h1234_8000, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 15, EV_ABS, 63, 32'h0000_7FFF, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 15, EV_ABS, 64, 32'h0000_7FFF, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 15, EV_ABS, 1023, 32'd0, 1'b0));
      pending.push_back(make_item(CMD_TICK, 0, 0, 0, 32'd0, 1'b0));
      pending.push_back(make_item(CMD_RESCAN, 0, 0, 0, 32'd0, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 15, EV_ABS, 63, 32'd0, 1'b0));
      pending.push_back(make_item(CMD_FINISH, 0, 0, 0, 32'd0, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 0, EV_ABS, 0, 32'h8000_7FFF, 1'b1));
      wait_quiet();

      // Launch at a short timeout, blocked while the menu is hidden or running.
      set_config(2, 0, 2000);
      repeat (3) pending.push_back(make_item(CMD_TICK, 0, 0, 0, 32'd0, 1'b1));
      pending.push_back(make_item(CMD_FINISH, 0, 0, 0, 32'd0, 1'b1));
      repeat (2) pending.push_back(make_item(CMD_TICK, 0, 0, 0, 32'd0, 1'b0));
      pending.push_back(make_item(CMD_TICK, 0, 0, 0, 32'd0, 1'b1));
      wait_quiet();

      write_csr(CSR_NEVER_LAUNCH, 1);
      pending.push_back(make_item(CMD_FINISH, 0, 0, 0, 32'd0, 1'b1));
      repeat (3) pending.push_back(make_item(CMD_TICK, 0, 0, 0, 32'd0, 1'b1));
      wait_quiet();

      // A zero timeout behaves as the default, and a zero deadzone passes any change.
      set_config(0, 0, 0);
      pending.push_back(make_item(CMD_FINISH, 0, 0, 0, 32'd0, 1'b1));
      repeat (3) pending.push_back(make_item(CMD_TICK, 0, 0, 0, 32'd0, 1'b1));
      pending.push_back(make_item(CMD_EVENT, 7, EV_ABS, 5, 32'd100, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 7, EV_ABS, 5, 32'd100, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 7, EV_ABS, 5, 32'd101, 1'b0));
      wait_quiet();

      write_csr(CSR_AXIS_DEADZONE, 16'hFFFF);
      pending.push_back(make_item(CMD_EVENT, 7, EV_ABS, 6, 32'h0000_8000, 1'b0));
      pending.push_back(make_item(CMD_EVENT, 7, EV_ABS, 6, 32'h0000_7FFF, 1'b0));
      wait_quiet();

      run_random_phase(145, 1, 0, 0);
      run_random_phase(145, 3, 0, 65535);
      run_random_phase(145, 2, 1, 500);
      run_random_phase(145, $urandom_range(1, 6), 0, 2000);
      run_random_phase(145, 0, 0, $urandom_range(0, 65535));
      run_random_phase(145, $urandom_range(1, 10), 0, $urandom_range(0, 4000));

      // Closing run without idling: launch after a longer timeout.
      idling_on = 1'b0;
      set_config(40, 0, $urandom_range(0, 65535));
      pending.push_back(make_item(CMD_FINISH, 0, 0, 0, 32'd0, 1'b1));
      repeat (41) begin
         pending.push_back(make_item(CMD_TICK, $urandom_range(0, 15), $urandom_range(0, 31),
                                     $urandom_range(0, 1023), $urandom, 1'b1));
      end
      pending.push_back(make_item(CMD_EVENT, 2, EV_KEY, 4, 32'd1, 1'b1));
      pending.push_back(make_item(CMD_TICK, 0, 0, 0, 32'd0, 1'b1));
      wait_quiet();
      repeat (10) @(posedge clock);

      if (mismatches == 0 && awaited.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
